// File: hw/rtl/rs_pkg.sv
// Shared constants, types and command/status structs for the record stack.
package rs_pkg;

	localparam int WORD_DEPTH   = 1024;
	localparam int RECORD_DEPTH = 64;
	localparam int RECORD_MAX   = 64;

	localparam int DATA_W = 32;
	localparam int WA_W   = $clog2(WORD_DEPTH);
	localparam int WC_W   = $clog2(WORD_DEPTH + 1);
	localparam int RA_W   = $clog2(RECORD_DEPTH);
	localparam int RC_W   = $clog2(RECORD_DEPTH + 1);
	localparam int LEN_W  = $clog2(RECORD_MAX + 1);

	typedef enum logic [1:0] {
		ST_VALUE    = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_OVERFLOW = 2'd2
	} rs_status_t;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef struct packed {
		logic do_push;
		logic do_overflow;
		logic do_empty;
		logic do_pop;
		logic do_start;
		logic do_word;
	} rs_cmd_t;

	typedef struct packed {
		logic stack_empty;
		logic push_fits;
		logic out_free;
		logic word_last;
	} rs_stat_t;

endpackage

// File: hw/rtl/rs_ram.sv
// Generic simple dual-port RAM with registered read data.
module rs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/rs_dp.sv
// Datapath: stack pointers, word and record-start memories, output register.
module rs_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rs_pkg::rs_cmd_t                    cmd,
	output rs_pkg::rs_stat_t                   stat,
	input  logic [rs_pkg::DATA_W-1:0]          push_value,
	input  logic                               push_last,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [rs_pkg::DATA_W-1:0]          m_tdata,
	output logic [1:0]                         m_tuser,
	output logic                               m_tlast
);
	import rs_pkg::*;

	logic [WC_W-1:0]   word_top_q;
	logic [RC_W-1:0]   count_q;
	logic              open_q;
	logic [LEN_W-1:0]  len_q;
	logic [WC_W-1:0]   ptr_q;
	logic [WC_W-1:0]   end_q;

	logic              out_valid_q;
	rs_status_t        out_status_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_last_q;

	logic              word_we;
	logic              word_re;
	logic [WA_W-1:0]   word_raddr;
	logic [DATA_W-1:0] word_rdata;
	logic              start_we;
	logic [WA_W-1:0]   start_rdata;
	logic [WC_W-1:0]   ptr_next;
	logic [RC_W-1:0]   count_dec;

	assign ptr_next  = ptr_q + WC_W'(1);
	assign count_dec = count_q - RC_W'(1);

	always_comb begin
		stat.stack_empty = (count_q == '0);
		stat.out_free    = !out_valid_q || m_tready;
		stat.word_last   = (ptr_next == end_q);
		if (word_top_q >= WC_W'(WORD_DEPTH)) begin
			stat.push_fits = 1'b0;
		end else if (open_q) begin
			stat.push_fits = (len_q < LEN_W'(RECORD_MAX));
		end else begin
			stat.push_fits = (count_q < RC_W'(RECORD_DEPTH));
		end
	end

	assign word_we  = cmd.do_push;
	assign start_we = cmd.do_push && !open_q;
	assign word_re  = cmd.do_start || (cmd.do_word && !stat.word_last);

	always_comb begin
		if (cmd.do_start) begin
			word_raddr = start_rdata;
		end else begin
			word_raddr = ptr_next[WA_W-1:0];
		end
	end

	rs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(WORD_DEPTH)
	) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_top_q[WA_W-1:0]),
		.wdata (push_value),
		.re    (word_re),
		.raddr (word_raddr),
		.rdata (word_rdata)
	);

	rs_ram #(
		.WIDTH(WA_W),
		.DEPTH(RECORD_DEPTH)
	) u_start_ram (
		.clk   (clk),
		.we    (start_we),
		.waddr (count_q[RA_W-1:0]),
		.wdata (word_top_q[WA_W-1:0]),
		.re    (cmd.do_pop),
		.raddr (count_dec[RA_W-1:0]),
		.rdata (start_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_top_q <= '0;
			count_q    <= '0;
			open_q     <= 1'b0;
			len_q      <= '0;
		end else begin
			if (cmd.do_push) begin
				word_top_q <= word_top_q + WC_W'(1);
				if (!open_q) begin
					count_q <= count_q + RC_W'(1);
				end
				if (push_last) begin
					open_q <= 1'b0;
					len_q  <= '0;
				end else begin
					open_q <= 1'b1;
					len_q  <= open_q ? len_q + LEN_W'(1) : LEN_W'(1);
				end
			end
			if (cmd.do_empty || cmd.do_pop) begin
				open_q <= 1'b0;
				len_q  <= '0;
			end
			if (cmd.do_pop) begin
				count_q <= count_dec;
			end
			if (cmd.do_start) begin
				word_top_q <= WC_W'(start_rdata);
			end
		end
	end

	// Read pointer and end mark of the record being popped.
	always_ff @(posedge clk) begin
		if (cmd.do_start) begin
			ptr_q <= WC_W'(start_rdata);
			end_q <= word_top_q;
		end else if (cmd.do_word) begin
			ptr_q <= ptr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.do_overflow || cmd.do_empty || cmd.do_word) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_overflow) begin
			out_status_q <= ST_OVERFLOW;
			out_value_q  <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.do_empty) begin
			out_status_q <= ST_EMPTY;
			out_value_q  <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.do_word) begin
			out_status_q <= ST_VALUE;
			out_value_q  <= word_rdata;
			out_last_q   <= stat.word_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hw/rtl/rs_ctrl.sv
// Controller state machine: accepts requests and sequences record pops.
module rs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tuser,
	output logic             s_tready,
	input  rs_pkg::rs_stat_t stat,
	output rs_pkg::rs_cmd_t  cmd
);
	import rs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_START = 3'b010,
		S_LOAD  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign s_tready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == REQ_PUSH) begin
						cmd.do_push     = stat.push_fits;
						cmd.do_overflow = !stat.push_fits;
					end else if (stat.stack_empty) begin
						cmd.do_empty = 1'b1;
					end else begin
						cmd.do_pop = 1'b1;
						state_d    = S_START;
					end
				end
			end
			S_START: begin
				cmd.do_start = 1'b1;
				state_d      = S_LOAD;
			end
			S_LOAD: begin
				if (stat.out_free) begin
					cmd.do_word = 1'b1;
					if (stat.word_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/record_stack.sv
// Top level of the record stack: controller, datapath and stream ports.
//
// A push transaction writes one word when it fits and yields a result only
// when it overflows. A pop transaction first fetches the record start
// pointer and then the first word (both memories have a registered read
// port), then streams the record at one value per cycle while the consumer
// keeps tready high. A new transaction is taken once the last value of a pop
// has been loaded into the output register and that register is free. Empty
// and overflow statuses are registered and come out in the cycle after their
// request. Both memories come up with undefined contents and need no
// clearing after reset.
module record_stack (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // push_value[31:0]
	input  logic        s_tuser,  // req_type
	input  logic        s_tlast,  // push_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_value[31:0]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast   // out_last
);
	import rs_pkg::*;

	rs_cmd_t  cmd;
	rs_stat_t stat;

	rs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.push_value (s_tdata),
		.push_last  (s_tlast),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// File: dv/record_stack_test.sv
// Self-checking stream testbench for the record stack with a behavioral stack mirror.
module record_stack_test;
	import rs_pkg::*;

	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 40;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		rs_status_t  status;
		logic [31:0] value;
		logic        last;
	} stack_result_t;

	// Mirrors the stack contents and keeps the results still owed by the block.
	class record_mirror;
		logic [31:0]   words[WORD_DEPTH];
		int unsigned   starts[RECORD_DEPTH];
		int unsigned   word_top = 0;
		int unsigned   record_count = 0;
		bit            is_open = 1'b0;
		int unsigned   open_len = 0;
		stack_result_t awaited[$];
		int            mismatches = 0;

		function void note_request(logic req, logic [31:0] value, logic last);
			int unsigned base;
			bit fits;
			if (req == REQ_PUSH) begin
				if (word_top >= WORD_DEPTH)
					fits = 1'b0;
				else if (is_open)
					fits = open_len < RECORD_MAX;
				else
					fits = record_count < RECORD_DEPTH;
				// A dropped push leaves everything alone, its last mark included.
				if (!fits) begin
					awaited.push_back('{ST_OVERFLOW, 32'd0, 1'b1});
					return;
				end
				if (!is_open) begin
					starts[record_count] = word_top;
					record_count++;
					is_open = 1'b1;
					open_len = 0;
				end
				words[word_top] = value;
				word_top++;
				open_len++;
				if (last) begin
					is_open = 1'b0;
					open_len = 0;
				end
			end else begin
				is_open = 1'b0;
				open_len = 0;
				if (record_count == 0) begin
					awaited.push_back('{ST_EMPTY, 32'd0, 1'b1});
					return;
				end
				record_count--;
				base = starts[record_count];
				for (int unsigned i = base; i < word_top; i++)
					awaited.push_back('{ST_VALUE, words[i], logic'(i + 1 == word_top)});
				word_top = base;
			end
		endfunction

		function void check_result(logic [1:0] status, logic [31:0] value, logic last);
			stack_result_t want;
			if (awaited.size() == 0) begin
				$error("unexpected transaction: status %0d out_value %h out_last %b",
					status, value, last);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				mismatches++;
			end
			if (value !== want.value) begin
				$error("out_value: expected %h, got %h", want.value, value);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("out_last: expected %b, got %b", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	record_mirror mirror = new;
	bit           steady = 1'b0;
	bit           hold_wanted = 1'b0;

	record_stack i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Entered just after a falling edge; returns just after the falling edge that
	// follows the accepting rising edge.
	task automatic send_item(logic req, logic [31:0] value, logic last);
		while (!steady && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= value;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		mirror.note_request(req, value, last);
		@(negedge clk);
	endtask

	task automatic push_value(logic [31:0] value, logic last);
		send_item(REQ_PUSH, value, last);
	endtask

	// Value and last mark are don't-care on a pop, so they are randomized.
	task automatic pop_record();
		send_item(REQ_POP, $urandom, 1'($urandom_range(1)));
	endtask

	task automatic push_record(int len, bit close);
		for (int i = 0; i < len; i++)
			push_value(pick_value(), close && i == len - 1);
	endtask

	initial begin : receiver
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= steady || $urandom_range(99) >= 16;
			@(posedge clk);
			if (m_tvalid && m_tready)
				mirror.check_result(m_tuser, m_tdata, m_tlast);
		end
	end

	initial begin : stimulus
		int n;
		int len;
		int r;
		bit close;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 32'd0;
		s_tuser  <= REQ_PUSH;
		s_tlast  <= 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		pop_record();
		push_value(32'h8000_0000, 1'b0);
		push_value(32'h7fff_ffff, 1'b0);
		push_value(32'h0000_0000, 1'b0);
		push_value(32'hffff_ffff, 1'b1);
		pop_record();
		push_value(32'h1234_5678, 1'b1);
		push_value(32'hedcb_a987, 1'b0);
		// The first pop closes the open record and takes it.
		pop_record();
		pop_record();
		pop_record();
		push_value(32'h5555_5555, 1'b0);
		pop_record();
		push_value(32'haaaa_aaaa, 1'b1);
		pop_record();

		// A full record refuses more values, and a refused last mark does not close it.
		push_record(RECORD_MAX, 1'b0);
		push_value(pick_value(), 1'b1);
		push_value(pick_value(), 1'b0);
		pop_record();

		// Fill the record table, then drain it against a long receiver stall.
		repeat (RECORD_DEPTH) push_record(1, 1'b1);
		push_value(pick_value(), 1'b1);
		hold_wanted = 1'b1;
		repeat (RECORD_DEPTH + 1) pop_record();

		n = 0;
		while (n < RANDOM_ITEMS) begin
			steady = n >= 10 && n < 30;
			r = $urandom_range(99);
			if (r < 45 || (mirror.record_count == 0 && r < 75)) begin
				if ($urandom_range(7) == 0)
					len = $urandom_range(RECORD_MAX + 2, 1);
				else
					len = $urandom_range(6, 1);
				close = $urandom_range(99) >= 15;
				for (int i = 0; i < len; i++)
					push_value(pick_value(),
						(close && i == len - 1) || $urandom_range(19) == 0);
				n += len;
			end else if (r < 88) begin
				pop_record();
				n++;
			end else begin
				push_value(pick_value(), 1'($urandom_range(1)));
				n++;
			end
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		while (mirror.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rs_pkg.sv
hw/rtl/rs_ram.sv
hw/rtl/rs_dp.sv
hw/rtl/rs_ctrl.sv
hw/rtl/record_stack.sv
dv/record_stack_test.sv
